FILE: hdl/assert_macros.svh
// ----------------------------------------------------------------------------
// assert_macros.svh
// Concurrent assertion shorthands included by the decoder unit.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Checks a property on every rising clock edge while the active-low reset is
// released.
`define ASSERT_CLK_RSTN(lbl, clk, rstn, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) else $error(msg);

// Checks a property on every rising clock edge, reset included.
`define ASSERT_CLK(lbl, clk, prop, msg) \
  lbl: assert property (@(posedge clk) (prop)) else $error(msg);

`endif

FILE: hdl/sfcd_pkg.sv
// ----------------------------------------------------------------------------
// sfcd_pkg
// Types, constants and the CRC-8 byte update shared by the frame decoder.
// ----------------------------------------------------------------------------
`default_nettype none

package sfcd_pkg;

  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  // Width of the scaled products (17500 * 65535 fits in 31 bits).
  localparam int unsigned PROD_W = 31;
  localparam int unsigned QUOT_W = 16;

  localparam logic [14:0] TEMP_SCALE  = 15'd17500;
  localparam logic [13:0] HUMID_SCALE = 14'd10000;
  localparam logic [14:0] TEMP_OFFSET = 15'd4500;

  // Position of a byte within the six-byte measurement frame.
  typedef enum logic [2:0] {
    POS_T_HI  = 3'd0,
    POS_T_LO  = 3'd1,
    POS_T_CRC = 3'd2,
    POS_H_HI  = 3'd3,
    POS_H_LO  = 3'd4,
    POS_H_CRC = 3'd5
  } byte_pos_e;

  // One byte of CRC-8, MSB first, no final xor.
  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] data);
    logic [7:0] c;
    c = crc ^ data;
    for (int i = 0; i < 8; i++) begin
      c = c[7] ? ((c << 1) ^ CRC_POLY) : (c << 1);
    end
    return c;
  endfunction

endpackage

`default_nettype wire

FILE: hdl/sfcd_div65535.sv
// ----------------------------------------------------------------------------
// sfcd_div65535
// Floor division of a product by 65535 without a divider.
// ----------------------------------------------------------------------------
`default_nettype none

module sfcd_div65535 (
  input  wire logic [sfcd_pkg::PROD_W-1:0] num_i,
  output logic      [sfcd_pkg::QUOT_W-1:0] quot_o
);
  import sfcd_pkg::*;

  logic [31:0]       num_ext;
  logic [31:0]       est_sum;
  logic [QUOT_W-1:0] quot_est;
  logic [31:0]       est_prod;
  logic [31:0]       rem_full;
  logic [16:0]       rem;

  // n/65535 is n/65536 * (1 + 2^-16 + ...); the first two terms give an
  // estimate that is low by at most one, fixed by one remainder compare.
  assign num_ext  = {{(32-PROD_W){1'b0}}, num_i};
  assign est_sum  = num_ext + (num_ext >> 16);
  assign quot_est = est_sum[31:16];
  assign est_prod = {quot_est, 16'h0000} - {16'h0000, quot_est};
  assign rem_full = num_ext - est_prod;
  assign rem      = rem_full[16:0];

  assign quot_o = quot_est + {{(QUOT_W-1){1'b0}}, (rem >= 17'd65535)};

endmodule

`default_nettype wire

FILE: hdl/sensor_frame_crc_decoder_unit.sv
// ----------------------------------------------------------------------------
// sensor_frame_crc_decoder_unit
// Six-byte sensor frame decoder with CRC-8 checks and fixed-point scaling.
// ----------------------------------------------------------------------------
// The slave stream carries one frame byte per transaction in tdata; tuser
// marks the first byte of a frame and forces the byte counter back to zero.
// A frame is temperature high, low, CRC, then humidity high, low, CRC. Each
// word is checked with CRC-8 (polynomial 0x31, initial value 0xFF).
// The master stream carries one result transaction per complete frame: both
// raw words, the converted values in hundredths and the three CRC flags.
// After its sixth byte is accepted, a result passes through the product register
// and then the result register before it leaves the block.
// A byte can be accepted every cycle while the product register can move on;
// the CRC covers the full byte at once; scaling uses two constant multipliers.
// When the receiver stalls, the result register holds its transaction and
// the product register can still take one more frame; bytes that complete no
// frame keep flowing as long as that register has room.
// Reset empties both registers, sets the byte counter to the first position
// and the running CRC to 0xFF; the block is ready right after reset.
// ----------------------------------------------------------------------------
`default_nettype none
`include "assert_macros.svh"

module sensor_frame_crc_decoder_unit (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  // Slave side: tdata[7:0] = rx_byte.
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  input  wire logic [7:0]  s_axis_tdata,
  // tuser[0] = frame_start.
  input  wire logic        s_axis_tuser,
  // Master side, from bit 0 up: temp_centi[14:0], humid_centi[28:15],
  // temp_raw[44:29], humid_raw[60:45], temp_crc_ok[61], humid_crc_ok[62],
  // frame_ok[63].
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  output logic [63:0]      m_axis_tdata
);
  import sfcd_pkg::*;

  // Frame assembly state.
  byte_pos_e   byte_pos_q, byte_pos_d;
  logic [7:0]  crc_q, crc_d;
  logic [15:0] temp_word_q, temp_word_d;
  logic [15:0] humid_word_q, humid_word_d;
  logic        temp_ok_q, temp_ok_d;

  // Product register: filled by the last byte of a frame.
  logic              prod_valid_q, prod_valid_d;
  logic [PROD_W-1:0] temp_prod_q;
  logic [PROD_W-1:0] humid_prod_q;
  logic [15:0]       prod_temp_raw_q;
  logic [15:0]       prod_humid_raw_q;
  logic              prod_temp_ok_q;
  logic              prod_humid_ok_q;

  // Result register.
  logic        res_valid_q, res_valid_d;
  logic [14:0] res_temp_q;
  logic [13:0] res_humid_q;
  logic [15:0] res_temp_raw_q;
  logic [15:0] res_humid_raw_q;
  logic        res_temp_ok_q;
  logic        res_humid_ok_q;

  logic        in_xfer;
  logic        res_adv;
  logic        prod_adv;
  byte_pos_e   pos_eff;
  logic        frame_done;
  logic        humid_ok;
  logic [7:0]  rx_byte;
  logic [QUOT_W-1:0] temp_quot;
  logic [QUOT_W-1:0] humid_quot;
  logic [14:0] temp_centi;

  assign rx_byte = s_axis_tdata;

  // The result register moves on when it is empty or being read; the product
  // register moves on when the result register does or when it is empty.
  assign res_adv       = !res_valid_q || m_axis_tready;
  assign prod_adv      = !prod_valid_q || res_adv;
  assign s_axis_tready = prod_adv;
  assign in_xfer       = s_axis_tvalid && s_axis_tready;

  // A start flag or an out-of-range count both restart at the first byte.
  always_comb begin
    if (s_axis_tuser || (byte_pos_q > POS_H_CRC)) begin
      pos_eff = POS_T_HI;
    end else begin
      pos_eff = byte_pos_q;
    end
  end

  assign humid_ok   = (crc_q == rx_byte);
  assign frame_done = in_xfer && (pos_eff == POS_H_CRC);

  always_comb begin
    byte_pos_d   = byte_pos_q;
    crc_d        = crc_q;
    temp_word_d  = temp_word_q;
    humid_word_d = humid_word_q;
    temp_ok_d    = temp_ok_q;
    if (in_xfer) begin
      unique case (pos_eff)
        POS_T_HI: begin
          crc_d       = crc8_byte(CRC_INIT, rx_byte);
          temp_word_d = {rx_byte, temp_word_q[7:0]};
          byte_pos_d  = POS_T_LO;
        end
        POS_T_LO: begin
          crc_d       = crc8_byte(crc_q, rx_byte);
          temp_word_d = {temp_word_q[15:8], rx_byte};
          byte_pos_d  = POS_T_CRC;
        end
        POS_T_CRC: begin
          temp_ok_d  = (crc_q == rx_byte);
          crc_d      = CRC_INIT;
          byte_pos_d = POS_H_HI;
        end
        POS_H_HI: begin
          crc_d        = crc8_byte(CRC_INIT, rx_byte);
          humid_word_d = {rx_byte, humid_word_q[7:0]};
          byte_pos_d   = POS_H_LO;
        end
        POS_H_LO: begin
          crc_d        = crc8_byte(crc_q, rx_byte);
          humid_word_d = {humid_word_q[15:8], rx_byte};
          byte_pos_d   = POS_H_CRC;
        end
        default: begin
          crc_d      = CRC_INIT;
          byte_pos_d = POS_T_HI;
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      byte_pos_q   <= POS_T_HI;
      crc_q        <= CRC_INIT;
      temp_word_q  <= '0;
      humid_word_q <= '0;
      temp_ok_q    <= 1'b0;
    end else begin
      byte_pos_q   <= byte_pos_d;
      crc_q        <= crc_d;
      temp_word_q  <= temp_word_d;
      humid_word_q <= humid_word_d;
      temp_ok_q    <= temp_ok_d;
    end
  end

  // Product register. The words are complete before the last CRC byte, so
  // the multipliers read the assembly registers directly.
  always_comb begin
    prod_valid_d = prod_valid_q;
    if (prod_adv) begin
      prod_valid_d = frame_done;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      prod_valid_q <= 1'b0;
    end else begin
      prod_valid_q <= prod_valid_d;
    end
  end

  // Both operands are widened first so the full product is kept.
  always_ff @(posedge clk_i) begin
    if (frame_done) begin
      temp_prod_q      <= PROD_W'(TEMP_SCALE) * PROD_W'(temp_word_q);
      humid_prod_q     <= PROD_W'(HUMID_SCALE) * PROD_W'(humid_word_q);
      prod_temp_raw_q  <= temp_word_q;
      prod_humid_raw_q <= humid_word_q;
      prod_temp_ok_q   <= temp_ok_q;
      prod_humid_ok_q  <= humid_ok;
    end
  end

  // Scaling: floor(product / 65535) for each word.
  sfcd_div65535 u_temp_div (
    .num_i  (temp_prod_q),
    .quot_o (temp_quot)
  );

  sfcd_div65535 u_humid_div (
    .num_i  (humid_prod_q),
    .quot_o (humid_quot)
  );

  assign temp_centi = temp_quot[14:0] - TEMP_OFFSET;

  // Result register.
  always_comb begin
    res_valid_d = res_valid_q;
    if (res_adv) begin
      res_valid_d = prod_valid_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_valid_q <= 1'b0;
    end else begin
      res_valid_q <= res_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_adv && prod_valid_q) begin
      res_temp_q      <= temp_centi;
      res_humid_q     <= humid_quot[13:0];
      res_temp_raw_q  <= prod_temp_raw_q;
      res_humid_raw_q <= prod_humid_raw_q;
      res_temp_ok_q   <= prod_temp_ok_q;
      res_humid_ok_q  <= prod_humid_ok_q;
    end
  end

  assign m_axis_tvalid = res_valid_q;
  assign m_axis_tdata  = {res_temp_ok_q && res_humid_ok_q, res_humid_ok_q, res_temp_ok_q,
                          res_humid_raw_q, res_temp_raw_q, res_humid_q, res_temp_q};

  // The byte counter never leaves the six frame positions.
  `ASSERT_CLK_RSTN(a_pos_range, clk_i, rst_ni, byte_pos_q <= POS_H_CRC, "byte position out of range")

  // The last byte of a frame always lands in the product register.
  `ASSERT_CLK_RSTN(a_frame_to_prod, clk_i, rst_ni, frame_done |=> prod_valid_q,
                   "completed frame not captured")

  // The humidity scaling never exceeds full scale.
  `ASSERT_CLK_RSTN(a_humid_range, clk_i, rst_ni,
                   m_axis_tvalid |-> (m_axis_tdata[28:15] <= 14'd10000),
                   "humidity out of range")

  // The temperature scaling never exceeds its top value.
  `ASSERT_CLK_RSTN(a_temp_quot_range, clk_i, rst_ni,
                   prod_valid_q |-> (temp_quot <= 16'd17500),
                   "temperature quotient out of range")

endmodule

`default_nettype wire

FILE: test/tb_sensor_frame_crc_decoder_unit.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_sensor_frame_crc_decoder_unit
// Self-checking bench for the six-byte sensor frame decoder. Frame bytes are
// streamed in bursts with random gaps. The receiver stalls in changing
// patterns. A scoreboard tracks the frame position, the CRCs and the words,
// and checks each decoded reading field by field.
// ----------------------------------------------------------------------------

// One decoded measurement as it appears on the master stream.
typedef struct {
  logic [14:0] temp_centi;
  logic [13:0] humid_centi;
  logic [15:0] temp_raw;
  logic [15:0] humid_raw;
  logic        temp_crc_ok;
  logic        humid_crc_ok;
  logic        frame_ok;
} sensor_reading_t;

// CRC-8 over one byte, fed MSB first one bit at a time.
function automatic logic [7:0] crc8_shift_byte(input logic [7:0] crc, input logic [7:0] data);
  logic [7:0] acc;
  logic       fb;
  acc = crc;
  for (int i = 7; i >= 0; i--) begin
    fb  = acc[7] ^ data[i];
    acc = {acc[6:0], 1'b0} ^ (fb ? sfcd_pkg::CRC_POLY : 8'h00);
  end
  return acc;
endfunction

// CRC byte that the sensor would append to a 16-bit word.
function automatic logic [7:0] word_crc(input logic [15:0] word);
  return crc8_shift_byte(crc8_shift_byte(sfcd_pkg::CRC_INIT, word[15:8]), word[7:0]);
endfunction

class frame_scoreboard;
  sfcd_pkg::byte_pos_e pos;
  logic [7:0]          crc;
  logic [15:0]         temp_word;
  logic [15:0]         humid_word;
  logic                temp_ok;
  sensor_reading_t     readings_due[$];
  int                  mismatches;
  int                  shown;

  function new();
    pos        = sfcd_pkg::POS_T_HI;
    crc        = sfcd_pkg::CRC_INIT;
    temp_word  = '0;
    humid_word = '0;
    temp_ok    = 1'b0;
    mismatches = 0;
    shown      = 0;
  endfunction

  function int pending();
    return readings_due.size();
  endfunction

  // Advances the decoder state by one accepted byte and queues the reading
  // that a completed frame produces.
  function void note_byte(input logic [7:0] b, input logic start);
    sensor_reading_t r;
    int unsigned     t_scaled;
    int unsigned     h_scaled;
    logic            h_ok;
    if (start) pos = sfcd_pkg::POS_T_HI;
    case (pos)
      sfcd_pkg::POS_T_HI: begin
        crc             = crc8_shift_byte(sfcd_pkg::CRC_INIT, b);
        temp_word[15:8] = b;
      end
      sfcd_pkg::POS_T_LO: begin
        crc            = crc8_shift_byte(crc, b);
        temp_word[7:0] = b;
      end
      sfcd_pkg::POS_T_CRC: begin
        temp_ok = (crc == b);
        crc     = sfcd_pkg::CRC_INIT;
      end
      sfcd_pkg::POS_H_HI: begin
        crc              = crc8_shift_byte(sfcd_pkg::CRC_INIT, b);
        humid_word[15:8] = b;
      end
      sfcd_pkg::POS_H_LO: begin
        crc             = crc8_shift_byte(crc, b);
        humid_word[7:0] = b;
      end
      default: begin
        h_ok           = (crc == b);
        t_scaled       = (32'd17500 * temp_word) / 32'd65535;
        h_scaled       = (32'd10000 * humid_word) / 32'd65535;
        r.temp_centi   = 15'(t_scaled - 32'd4500);
        r.humid_centi  = 14'(h_scaled);
        r.temp_raw     = temp_word;
        r.humid_raw    = humid_word;
        r.temp_crc_ok  = temp_ok;
        r.humid_crc_ok = h_ok;
        r.frame_ok     = temp_ok & h_ok;
        readings_due.push_back(r);
        crc = sfcd_pkg::CRC_INIT;
      end
    endcase
    pos = (pos == sfcd_pkg::POS_H_CRC) ? sfcd_pkg::POS_T_HI : sfcd_pkg::byte_pos_e'(pos + 3'd1);
  endfunction

  function void report(input string what);
    mismatches++;
    if (shown < 10) begin
      shown++;
      $display("[%0t] %s", $time, what);
    end
  endfunction

  // Compares one accepted result transaction with the oldest expected reading.
  function void check_reading(input logic [63:0] d);
    sensor_reading_t got;
    sensor_reading_t want;
    logic            bad;
    got.temp_centi   = d[14:0];
    got.humid_centi  = d[28:15];
    got.temp_raw     = d[44:29];
    got.humid_raw    = d[60:45];
    got.temp_crc_ok  = d[61];
    got.humid_crc_ok = d[62];
    got.frame_ok     = d[63];
    if (readings_due.size() == 0) begin
      report($sformatf("unexpected reading, tdata=%h", d));
      return;
    end
    want = readings_due.pop_front();
    bad  = (got.temp_centi !== want.temp_centi) || (got.humid_centi !== want.humid_centi)
        || (got.temp_raw !== want.temp_raw) || (got.humid_raw !== want.humid_raw)
        || (got.temp_crc_ok !== want.temp_crc_ok)
        || (got.humid_crc_ok !== want.humid_crc_ok) || (got.frame_ok !== want.frame_ok);
    if (bad) begin
      report($sformatf({"reading mismatch: expected t=%0d h=%0d traw=%h hraw=%h ok=%b%b%b,",
                        " actual t=%0d h=%0d traw=%h hraw=%h ok=%b%b%b"},
                       $signed(want.temp_centi), want.humid_centi, want.temp_raw,
                       want.humid_raw, want.temp_crc_ok, want.humid_crc_ok, want.frame_ok,
                       $signed(got.temp_centi), got.humid_centi, got.temp_raw,
                       got.humid_raw, got.temp_crc_ok, got.humid_crc_ok, got.frame_ok));
    end
  endfunction
endclass

module tb_sensor_frame_crc_decoder_unit;

  localparam int RANDOM_ITEMS = 1650;
  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 8;

  // Receiver back-pressure patterns.
  typedef enum int {RX_FREE, RX_RANDOM, RX_SLOW} rx_mode_e;

  logic        clk_i         = 1'b0;
  logic        rst_ni        = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata  = '0;    // rx_byte[7:0]
  logic        s_axis_tuser  = 1'b0;  // frame_start[0]
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  // temp_centi[14:0], humid_centi[28:15], temp_raw[44:29], humid_raw[60:45],
  // temp_crc_ok[61], humid_crc_ok[62], frame_ok[63]
  logic [63:0] m_axis_tdata;

  frame_scoreboard sb = new();
  int              bytes_sent  = 0;
  int              burst_left  = 0;
  int              cycle_count = 0;
  rx_mode_e        rx_mode     = RX_FREE;
  int              mode_left   = 0;
  int unsigned     slow_phase  = 0;

  sensor_frame_crc_decoder_unit DUT (
    .clk_i         (clk_i),
    .rst_ni        (rst_ni),
    .s_axis_tvalid (s_axis_tvalid),
    .s_axis_tready (s_axis_tready),
    .s_axis_tdata  (s_axis_tdata),
    .s_axis_tuser  (s_axis_tuser),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata)
  );

  always begin
    #6 clk_i = 1'b1;
    #6 clk_i = 1'b0;
  end

  // Watchdog against a hung handshake.
  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Result side: every accepted transaction is checked at the rising edge.
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid && m_axis_tready) sb.check_reading(m_axis_tdata);
  end

  // The receiver switches between free flow, random stalls and a slow
  // pattern that is ready only when the low three bits of a phase counter are zero.
  always @(negedge clk_i) begin
    slow_phase <= slow_phase + 1;
    if (mode_left == 0) begin
      rx_mode   <= rx_mode_e'($urandom_range(0, 2));
      mode_left <= $urandom_range(32, 200);
    end else begin
      mode_left <= mode_left - 1;
    end
    case (rx_mode)
      RX_FREE:   m_axis_tready <= 1'b1;
      RX_RANDOM: m_axis_tready <= 1'($urandom_range(0, 1));
      default:   m_axis_tready <= (slow_phase[2:0] == 3'd0);
    endcase
  end

  // Presents one byte and holds it until the block takes it. Entered and left
  // at a falling edge; a new burst may start after a random gap with tvalid low.
  task automatic send_byte(input logic [7:0] b, input logic start);
    int gap;
    if (burst_left == 0) begin
      gap        = ($urandom_range(0, 9) < 4) ? 0 : $urandom_range(1, 6);
      burst_left = $urandom_range(1, 24);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(negedge clk_i);
      end
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tuser  <= start;
    @(posedge clk_i);
    while (!s_axis_tready) @(posedge clk_i);
    sb.note_byte(b, start);
    bytes_sent++;
    burst_left--;
    @(negedge clk_i);
  endtask

  // Sends a whole frame; a nonzero corrupt mask flips bits of that CRC byte.
  task automatic send_frame(input logic [15:0] tw, input logic [15:0] hw,
                            input logic [7:0] t_corrupt, input logic [7:0] h_corrupt,
                            input logic start);
    send_byte(tw[15:8], start);
    send_byte(tw[7:0], 1'b0);
    send_byte(word_crc(tw) ^ t_corrupt, 1'b0);
    send_byte(hw[15:8], 1'b0);
    send_byte(hw[7:0], 1'b0);
    send_byte(word_crc(hw) ^ h_corrupt, 1'b0);
  endtask

  function automatic logic [15:0] pick_word();
    case ($urandom_range(0, 15))
      0:       return 16'h0000;
      1:       return 16'hFFFF;
      2:       return 16'h0001;
      3:       return 16'hFFFE;
      default: return 16'($urandom());
    endcase
  endfunction

  function automatic logic [7:0] pick_corrupt();
    return ($urandom_range(0, 99) < 85) ? 8'h00 : 8'($urandom_range(1, 255));
  endfunction

  initial begin
    int kind;
    int n;
    repeat (3) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    // Directed part: scale extremes, each CRC flag failing on its own, a
    // frame that begins without the start flag, and a frame start that
    // lands in the middle of a frame.
    send_frame(16'h0000, 16'hFFFF, 8'h00, 8'h00, 1'b1);
    send_frame(16'hFFFF, 16'h0000, 8'h5A, 8'h00, 1'b0);
    send_byte(8'hA5, 1'b1);
    send_byte(8'h3C, 1'b0);
    send_byte(8'h77, 1'b0);
    send_frame(16'h6666, 16'h8000, 8'h00, 8'h01, 1'b1);
    send_frame(16'h8000, 16'h7FFF, 8'h80, 8'hFF, 1'b1);

    // Random part: mostly well-formed frames, some cut short, some noise.
    while (bytes_sent < RANDOM_ITEMS) begin
      kind = $urandom_range(0, 99);
      if (kind < 82) begin
        send_frame(pick_word(), pick_word(), pick_corrupt(), pick_corrupt(),
                   1'($urandom_range(0, 1)));
      end else if (kind < 92) begin
        n = $urandom_range(1, 5);
        for (int i = 0; i < n; i++) send_byte(8'($urandom()), (i == 0));
        send_frame(pick_word(), pick_word(), pick_corrupt(), pick_corrupt(), 1'b1);
      end else begin
        n = $urandom_range(1, 8);
        for (int i = 0; i < n; i++) send_byte(8'($urandom()), 1'($urandom_range(0, 3) == 0));
      end
    end
    s_axis_tvalid <= 1'b0;

    while (sb.pending() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    if (sb.mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule
